@@ rtl/tlec_pkg.sv @@
// Shared types, constants and helpers for the text line ending converter.
package tlec_pkg;

  localparam logic [1:0] MODE_READ       = 2'd0;
  localparam logic [1:0] MODE_WRITE_PASS = 2'd1;
  localparam logic [1:0] MODE_WRITE_CRLF = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int MARK_LENGTH = 3;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Value of the mark stage once the mark question is settled.
  localparam logic [1:0] STAGE_DONE = 2'(MARK_LENGTH);

  // Up to three result bytes caused by one accepted input beat.
  typedef struct packed {
    logic [1:0]                    count;
    logic [MAX_RESULTS-1:0][7:0]   bytes;
    logic                          byte_valid;
    logic                          fin;
    logic                          mark;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] mark_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      2'd2:    b = 8'hBF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/text_line_ending_converter.sv @@
// Top level of the text line ending converter: mode register, front end, queue, back end.
//
//   channel  direction  handshake              payload
//   in_      input      in_tvalid/in_tready    tdata byte, tuser has_byte, tlast finish
//   out_     output     out_tvalid/out_tready  tdata byte+last_of_run, tuser, tlast end
//   cfg_     input      cfg_valid/cfg_ready    cfg_data direction_mode
//
// An input beat is taken while the queue is not full; it yields zero to three result
// beats, sent one per cycle by the back end while out_tready is held high. A bundle
// queue of QUEUE_DEPTH entries, two by default, lets the front run while the output
// stalls. Synchronous active-low reset clears mode, mark and CR state, and the queue.
// The configuration port is always ready.
module text_line_ending_converter #(
  parameter int QUEUE_DEPTH = tlec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] last_of_run, [15:9] zero
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] mark_found
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import tlec_pkg::*;

  logic [1:0] mode_r, mode_nxt;
  logic       push, pop;
  bundle_t    push_data, head;
  q_status_t  q_status;

  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_READ;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  tlec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  tlec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tlec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full) else $error("bundle pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty) else $error("bundle popped from an empty queue");

  a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata[8]))
    else $error("bare end marker without end flags");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tdata[8])
    else $error("stream end on a beat that is not last of its run");
`endif

endmodule

@@ rtl/tlec_front.sv @@
// Front end: accepts input beats, tracks mark and CR state, builds result bundles.
module tlec_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         mode,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  tlec_pkg::q_status_t q_status,
  output logic               push,
  output tlec_pkg::bundle_t  push_data
);
  import tlec_pkg::*;

  localparam int NCAND = 6;

  logic [1:0] stage_r, stage_nxt;
  logic       cr_r, cr_nxt;
  logic       seen_r, seen_nxt;

  logic       accept;
  logic       rd, st3, has, fin;
  logic       match, mism;
  logic [1:0] stage_a;
  logic       cr_a, seen_a;
  logic [1:0] rel_cnt;
  logic [NCAND-1:0]      cand_en;
  logic [NCAND-1:0][7:0] cand_byte;
  logic [MAX_RESULTS-1:0][7:0] slot;
  logic [2:0] n;

  assign in_tready = !q_status.full;
  assign accept    = in_tvalid && in_tready;
  assign has       = in_tuser;
  assign fin       = in_tlast;
  assign rd        = (mode == MODE_READ);
  assign st3       = (stage_r == STAGE_DONE);

  always_comb begin
    match = rd && has && !st3 && (in_tdata == mark_byte(stage_r));
    mism  = rd && has && !st3 && (in_tdata != mark_byte(stage_r));

    if (match) begin
      stage_a = (stage_r == STAGE_DONE - 2'd1) ? STAGE_DONE : stage_r + 2'd1;
    end else if (mism) begin
      stage_a = STAGE_DONE;
    end else begin
      stage_a = stage_r;
    end

    seen_a = seen_r || (match && (stage_r == STAGE_DONE - 2'd1));

    // A byte that goes through CR handling leaves a pending CR exactly when it is a CR.
    if (rd && has && (st3 || mism)) begin
      cr_a = (in_tdata == CHAR_CR);
    end else begin
      cr_a = cr_r;
    end

    // Held mark bytes always equal the leading mark bytes, so they are released
    // from the constant rather than from storage.
    if (mism) begin
      rel_cnt = stage_r;
    end else if (rd && fin && (stage_a != STAGE_DONE)) begin
      rel_cnt = stage_a;
    end else begin
      rel_cnt = 2'd0;
    end

    cand_en[0]   = rd && has && st3 && cr_r && (in_tdata != CHAR_LF);
    cand_byte[0] = CHAR_CR;
    cand_en[1]   = (rel_cnt >= 2'd1);
    cand_byte[1] = mark_byte(2'd0);
    cand_en[2]   = (rel_cnt >= 2'd2);
    cand_byte[2] = mark_byte(2'd1);
    cand_en[3]   = !rd && has && (mode == MODE_WRITE_CRLF) && (in_tdata == CHAR_LF);
    cand_byte[3] = CHAR_CR;
    cand_en[4]   = rd ? (has && (st3 || mism) && (in_tdata != CHAR_CR)) : has;
    cand_byte[4] = in_tdata;
    cand_en[5]   = rd && fin && cr_a;
    cand_byte[5] = CHAR_CR;

    slot = '0;
    n    = 3'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_en[i] && (n < 3'(MAX_RESULTS))) begin
        slot[n[1:0]] = cand_byte[i];
        n            = n + 3'd1;
      end
    end

    if (accept && fin) begin
      stage_nxt = 2'd0;
      cr_nxt    = 1'b0;
      seen_nxt  = 1'b0;
    end else if (accept) begin
      stage_nxt = stage_a;
      cr_nxt    = cr_a;
      seen_nxt  = seen_a;
    end else begin
      stage_nxt = stage_r;
      cr_nxt    = cr_r;
      seen_nxt  = seen_r;
    end
  end

  assign push                 = accept && ((n != 3'd0) || fin);
  assign push_data.count      = (n == 3'd0) ? 2'd1 : n[1:0];
  assign push_data.bytes      = slot;
  assign push_data.byte_valid = (n != 3'd0);
  assign push_data.fin        = fin;
  assign push_data.mark       = seen_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 2'd0;
      cr_r    <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      cr_r    <= cr_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

@@ rtl/tlec_queue.sv @@
// Short bundle queue between the front end and the output serializer.
module tlec_queue #(
  parameter int DEPTH = tlec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tlec_pkg::bundle_t   push_data,
  input  logic                pop,
  output tlec_pkg::bundle_t   head,
  output tlec_pkg::q_status_t status
);
  import tlec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t        mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/tlec_back.sv @@
// Back end: walks the head bundle one result at a time into the output register.
module tlec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tlec_pkg::bundle_t   head,
  input  tlec_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import tlec_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, bvalid_nxt;
  logic       last_r, last_nxt;
  logic       end_r, end_nxt;
  logic       mark_r, mark_nxt;

  logic       load, is_last;
  logic [7:0] sel_byte;

  assign load    = !q_status.empty && (!valid_r || out_tready);
  assign is_last = (idx_r == head.count - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[2];
      default: sel_byte = 8'h00;
    endcase

    idx_nxt    = idx_r;
    valid_nxt  = valid_r;
    byte_nxt   = byte_r;
    bvalid_nxt = bvalid_r;
    last_nxt   = last_r;
    end_nxt    = end_r;
    mark_nxt   = mark_r;
    if (load) begin
      idx_nxt    = is_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt  = 1'b1;
      byte_nxt   = sel_byte;
      bvalid_nxt = head.byte_valid;
      last_nxt   = is_last;
      end_nxt    = is_last && head.fin;
      mark_nxt   = head.mark;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
    end_r    <= end_nxt;
    mark_r   <= mark_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, last_r, byte_r};
  assign out_tuser  = {mark_r, bvalid_r};
  assign out_tlast  = end_r;

endmodule
